// ===== rtl/core/sis_pkg.sv =====
// Shared types for the stack insertion sorter: data word and per-cell control bundle.
`default_nettype none
package sis_pkg;

  localparam int unsigned DataWidth = 32;

  typedef logic signed [DataWidth-1:0] data_t;

  // Control broadcast from the sequencer to every cell in the chain
  typedef struct packed {
    logic ins;    // insert the broadcast value this cycle
    logic drain;  // shift the chain one place toward the head
  } sis_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/core/sis_cell.sv =====
// One cell of the insertion chain: holds one sorted entry and its valid bit.
`default_nettype none
module sis_cell
  import sis_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire sis_ctrl_t ctrl,
  input  wire data_t     new_value,
  input  wire logic      upper_gt,
  input  wire data_t     upper_value,
  input  wire logic      upper_valid,
  input  wire data_t     lower_value,
  input  wire logic      lower_valid,
  output logic           gt,
  output data_t          entry,
  output logic           entry_valid
);

  // New value belongs above this entry (an empty cell always yields)
  assign gt = !entry_valid || (new_value > entry);

  // Payload: take the new value, the entry from above, or the one from below
  always_ff @(posedge clk) begin
    if (ctrl.ins && gt) begin
      entry <= upper_gt ? upper_value : new_value;
    end else if (ctrl.drain) begin
      entry <= lower_value;
    end
  end

  // Valid bit: follows the entry that moves in
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (ctrl.ins && gt) begin
      entry_valid <= upper_gt ? upper_valid : 1'b1;
    end else if (ctrl.drain) begin
      entry_valid <= lower_valid;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/stack_insertion_sorter.sv =====
// Top level of the stack insertion sorter: a chain of sorting cells and its sequencer.
//
//   channel | handshake                 | payload
//   --------+---------------------------+----------------------------------
//   in      | in_valid / in_stall       | value, last
//   out     | out_valid / out_stall     | sorted_value, final_res, overflow
//
// On each request the value is broadcast to all cells, each compares
// it with its entry, and the entries below the insertion point move
// down one cell. After a request with last set, the chain drains from
// cell 0, one result per cycle while out_stall is low.
// in_stall is high for the whole drain. Reset clears every valid bit and
// the sequencer; no clearing pass is needed.
`default_nettype none
module stack_insertion_sorter
  import sis_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] value,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      sorted_value,
  output logic             final_res,
  output logic             overflow
);

  logic       draining;
  logic       dropped;
  logic       in_take;
  logic       out_take;
  logic       full;
  sis_ctrl_t  ctrl;
  data_t      new_value;

  logic  [CAPACITY-1:0] cell_gt;
  logic  [CAPACITY-1:0] cell_valid;
  data_t                cell_entry [CAPACITY];

  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;
  assign full      = cell_valid[CAPACITY-1];
  assign new_value = data_t'(value);

  assign ctrl.ins   = in_take && !full;
  assign ctrl.drain = out_take;

  // Build the chain: cell 0 is the top of the stack
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    data_t up_value;
    data_t lo_value;
    logic  up_gt;
    logic  up_valid;
    logic  lo_valid;

    if (i == 0) begin : g_head
      assign up_gt    = 1'b0;
      assign up_value = new_value;
      assign up_valid = 1'b1;
    end else begin : g_body
      assign up_gt    = cell_gt[i-1];
      assign up_value = cell_entry[i-1];
      assign up_valid = cell_valid[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign lo_value = cell_entry[i];
      assign lo_valid = 1'b0;
    end else begin : g_mid
      assign lo_value = cell_entry[i+1];
      assign lo_valid = cell_valid[i+1];
    end

    sis_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .new_value   (new_value),
      .upper_gt    (up_gt),
      .upper_value (up_value),
      .upper_valid (up_valid),
      .lower_value (lo_value),
      .lower_valid (lo_valid),
      .gt          (cell_gt[i]),
      .entry       (cell_entry[i]),
      .entry_valid (cell_valid[i])
    );
  end

  // Sequencer: enter drain after a last request, leave when the final result goes
  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
    end else if (in_take && last) begin
      draining <= 1'b1;
    end else if (out_take && !cell_valid[1]) begin
      draining <= 1'b0;
    end
  end

  // Sticky overflow: set on a dropped value, clear at end of batch
  always_ff @(posedge clk) begin
    if (rst) begin
      dropped <= 1'b0;
    end else if (in_take && full) begin
      dropped <= 1'b1;
    end else if (out_take && !cell_valid[1]) begin
      dropped <= 1'b0;
    end
  end

  // Drive the ports from the head of the chain
  assign in_stall     = draining;
  assign out_valid    = draining;
  assign sorted_value = 32'(cell_entry[0]);
  assign final_res    = !cell_valid[1];
  assign overflow     = dropped;

endmodule
`default_nettype wire
